>>> src/bcas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcas_pkg
// Types, constants and small helpers for the beep-code alert sequencer.
// ----------------------------------------------------------------------------
package bcas_pkg;

    // number of units that can be reported (mask carries four bits)
    localparam int UNIT_COUNT = 4;
    localparam int UNIT_SPAN  = (UNIT_COUNT < 4) ? UNIT_COUNT : 4;
    localparam logic [3:0] UNIT_LIMIT = 4'((1 << UNIT_SPAN) - 1);

    // boot melody frequencies
    localparam logic [15:0] MELODY_HZ_0    = 16'd1046;
    localparam logic [15:0] MELODY_HZ_1    = 16'd1174;
    localparam logic [15:0] MELODY_HZ_LAST = 16'd1568;

    // event codes
    localparam logic ACT_START  = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_NOTE_MS       = 3'd0;
    localparam logic [2:0] REG_GRACE_MS      = 3'd1;
    localparam logic [2:0] REG_ALARM_HZ      = 3'd2;
    localparam logic [2:0] REG_BEEP_MS       = 3'd3;
    localparam logic [2:0] REG_BEEP_GAP_MS   = 3'd4;
    localparam logic [2:0] REG_UNIT_GAP_MS   = 3'd5;
    localparam logic [2:0] REG_REPEAT_GAP_MS = 3'd6;

    // sequencer phases
    typedef enum logic [5:0] {
        PH_BOOT       = 6'b000001,
        PH_IDLE       = 6'b000010,
        PH_TONE       = 6'b000100,
        PH_TONE_GAP   = 6'b001000,
        PH_UNIT_GAP   = 6'b010000,
        PH_REPEAT_GAP = 6'b100000
    } phase_t;

    // input word
    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [3:0]  offline_mask;
    } evt_word_t;

    // result word
    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_hz;
    } tone_word_t;

    // result of the offline unit search
    typedef struct packed {
        logic       found;
        logic [1:0] idx;
    } unit_hit_t;

    // melody note frequency, notes past the third repeat it
    function automatic logic [15:0] melody_hz(input logic [2:0] idx);
        logic [15:0] hz;
        case (idx)
            3'd0:    hz = MELODY_HZ_0;
            3'd1:    hz = MELODY_HZ_1;
            default: hz = MELODY_HZ_LAST;
        endcase
        return hz;
    endfunction

    // lowest offline unit at or above start
    function automatic unit_hit_t first_unit(input logic [3:0] mask, input logic [2:0] start);
        unit_hit_t hit;
        hit = '0;
        for (int i = 3; i >= 0; i--)
        begin
            if (mask[i] && UNIT_LIMIT[i] && (3'(i) >= start))
            begin
                hit.found = 1'b1;
                hit.idx   = 2'(i);
            end
        end
        return hit;
    endfunction

endpackage
`default_nettype wire

>>> src/beep_code_alert_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// beep_code_alert_sequencer_core
// Boot melody/offline-unit beep code sequencer; one event per unstalled cycle
// ----------------------------------------------------------------------------
//  channel | signals                          | direction | transfer
//  evt     | evt_valid, evt_stall, evt        | in        | valid & !stall
//  tone    | tone_valid, tone_stall, tone     | out       | valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index,  | in        | valid & ready
//          | cfg_data                         |           |
//
//  one event per cycle while tone does not stall; each result is built through
//  the input register, then next-state logic into the result register
//  evaluation uses two 32-bit wrap compares, two 4-bit searches, one 32-bit add
//  reset clears the sequencer state and loads the register defaults
//  a stall on tone holds the result register and backs up into evt_stall
//  cfg_ready is always high
// ----------------------------------------------------------------------------
module beep_code_alert_sequencer_core
    import bcas_pkg::*;
#(
    parameter int MELODY_NOTES = 3
)(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        evt_valid,
    output logic             evt_stall,
    input  wire evt_word_t   evt,
    output logic             tone_valid,
    input  wire logic        tone_stall,
    output tone_word_t       tone,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int NOTE_W = $clog2(MELODY_NOTES + 1);

    // configuration registers
    logic [15:0] note_ms_reg, grace_ms_reg, alarm_hz_reg, beep_ms_reg;
    logic [15:0] beep_gap_ms_reg, unit_gap_ms_reg, repeat_gap_ms_reg;

    // pipeline registers
    logic        in_valid_reg;
    evt_word_t   in_word_reg;
    logic        tone_valid_reg;
    tone_word_t  tone_word_reg;

    // sequencer state
    phase_t      phase_reg, phase_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [31:0] aet_reg, aet_next;
    logic [NOTE_W-1:0] note_index_reg, note_index_next;
    logic [3:0]  active_mask_reg, active_mask_next;
    logic [1:0]  unit_index_reg, unit_index_next;
    logic [2:0]  beeps_left_reg, beeps_left_next;
    logic        sounding_reg, sounding_next;
    logic [15:0] frequency_reg, frequency_next;

    // evaluation signals
    logic        evt_fire, advance;
    logic [31:0] now, dl_diff, aet_diff, sum;
    logic [3:0]  mask;
    logic        dl_reached, aet_reached, mask_chg;
    phase_t      cur_phase;
    logic [15:0] add_dur;
    logic        dl_load, aet_load;
    logic [NOTE_W-1:0] note_inc;
    logic [3:0]  note_ext;
    logic [2:0]  beeps_dec;
    unit_hit_t   hit_first, hit_next;

    // handshakes
    assign cfg_ready  = 1'b1;
    assign advance    = in_valid_reg && (!tone_valid_reg || !tone_stall);
    assign evt_stall  = in_valid_reg && tone_valid_reg && tone_stall;
    assign evt_fire   = evt_valid && !evt_stall;
    assign tone_valid = tone_valid_reg;
    assign tone       = tone_word_reg;

    // configuration write decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_ms_reg       <= 16'd250;
            grace_ms_reg      <= 16'd2000;
            alarm_hz_reg      <= 16'd1000;
            beep_ms_reg       <= 16'd120;
            beep_gap_ms_reg   <= 16'd120;
            unit_gap_ms_reg   <= 16'd500;
            repeat_gap_ms_reg <= 16'd2000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NOTE_MS:       note_ms_reg       <= cfg_data;
                REG_GRACE_MS:      grace_ms_reg      <= cfg_data;
                REG_ALARM_HZ:      alarm_hz_reg      <= cfg_data;
                REG_BEEP_MS:       beep_ms_reg       <= cfg_data;
                REG_BEEP_GAP_MS:   beep_gap_ms_reg   <= cfg_data;
                REG_UNIT_GAP_MS:   unit_gap_ms_reg   <= cfg_data;
                REG_REPEAT_GAP_MS: repeat_gap_ms_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire)
        begin
            in_word_reg <= evt;
        end
    end

    // deadline compares by wrapped signed difference
    assign now         = in_word_reg.now_ms;
    assign mask        = in_word_reg.offline_mask;
    assign dl_diff     = now - deadline_reg;
    assign aet_diff    = now - aet_reg;
    assign dl_reached  = !dl_diff[31];
    assign aet_reached = !aet_diff[31];
    assign mask_chg    = (mask != active_mask_reg);
    assign cur_phase   = mask_chg ? PH_IDLE : phase_reg;
    assign sum         = now + {16'd0, add_dur};
    assign note_inc    = note_index_reg + NOTE_W'(1);
    assign note_ext    = 4'(note_inc);
    assign beeps_dec   = (beeps_left_reg != 3'd0) ? (beeps_left_reg - 3'd1) : 3'd0;
    assign hit_first   = first_unit(mask, 3'd0);
    assign hit_next    = first_unit(mask, {1'b0, unit_index_reg} + 3'd1);

    // next state for one event
    always_comb
    begin
        phase_next       = phase_reg;
        note_index_next  = note_index_reg;
        active_mask_next = active_mask_reg;
        unit_index_next  = unit_index_reg;
        beeps_left_next  = beeps_left_reg;
        sounding_next    = sounding_reg;
        frequency_next   = frequency_reg;
        add_dur          = note_ms_reg;
        dl_load          = 1'b0;
        aet_load         = 1'b0;
        aet_next         = aet_reg;

        if (in_word_reg.action == ACT_START)
        begin
            // restart the boot melody
            phase_next       = PH_BOOT;
            dl_load          = 1'b1;
            aet_next         = 32'd0;
            note_index_next  = '0;
            active_mask_next = 4'd0;
            unit_index_next  = 2'd0;
            beeps_left_next  = 3'd0;
            frequency_next   = MELODY_HZ_0;
            sounding_next    = 1'b1;
        end
        else if (phase_reg == PH_BOOT)
        begin
            // step the melody
            if (dl_reached)
            begin
                note_index_next = note_inc;
                if (note_inc < NOTE_W'(MELODY_NOTES))
                begin
                    frequency_next = melody_hz(note_ext[2:0]);
                    sounding_next  = 1'b1;
                    dl_load        = 1'b1;
                end
                else
                begin
                    sounding_next = 1'b0;
                    phase_next    = PH_IDLE;
                    add_dur       = grace_ms_reg;
                    aet_load      = 1'b1;
                end
            end
        end
        else if (aet_reached)
        begin
            // mask change silences and restarts the report
            if (mask_chg)
            begin
                active_mask_next = mask;
                phase_next       = PH_IDLE;
                sounding_next    = 1'b0;
            end
            if (mask != 4'd0)
            begin
                if ((cur_phase == PH_IDLE) || (dl_reached && (cur_phase == PH_REPEAT_GAP)))
                begin
                    if (hit_first.found)
                    begin
                        unit_index_next = hit_first.idx;
                        beeps_left_next = {1'b0, hit_first.idx} + 3'd1;
                        frequency_next  = alarm_hz_reg;
                        sounding_next   = 1'b1;
                        phase_next      = PH_TONE;
                        add_dur         = beep_ms_reg;
                        dl_load         = 1'b1;
                    end
                end
                else if (dl_reached)
                begin
                    if (cur_phase == PH_TONE)
                    begin
                        sounding_next   = 1'b0;
                        beeps_left_next = beeps_dec;
                        dl_load         = 1'b1;
                        if (beeps_dec != 3'd0)
                        begin
                            phase_next = PH_TONE_GAP;
                            add_dur    = beep_gap_ms_reg;
                        end
                        else if (hit_next.found)
                        begin
                            unit_index_next = hit_next.idx;
                            beeps_left_next = {1'b0, hit_next.idx} + 3'd1;
                            phase_next      = PH_UNIT_GAP;
                            add_dur         = unit_gap_ms_reg;
                        end
                        else
                        begin
                            phase_next = PH_REPEAT_GAP;
                            add_dur    = repeat_gap_ms_reg;
                        end
                    end
                    else if ((cur_phase == PH_TONE_GAP) || (cur_phase == PH_UNIT_GAP))
                    begin
                        frequency_next = alarm_hz_reg;
                        sounding_next  = 1'b1;
                        phase_next     = PH_TONE;
                        add_dur        = beep_ms_reg;
                        dl_load        = 1'b1;
                    end
                end
            end
        end

        deadline_next = dl_load ? sum : deadline_reg;
        if (aet_load)
        begin
            aet_next = sum;
        end
    end

    // sequencer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_BOOT;
            deadline_reg    <= 32'd0;
            aet_reg         <= 32'd0;
            note_index_reg  <= '0;
            active_mask_reg <= 4'd0;
            unit_index_reg  <= 2'd0;
            beeps_left_reg  <= 3'd0;
            sounding_reg    <= 1'b0;
            frequency_reg   <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            deadline_reg    <= deadline_next;
            aet_reg         <= aet_next;
            note_index_reg  <= note_index_next;
            active_mask_reg <= active_mask_next;
            unit_index_reg  <= unit_index_next;
            beeps_left_reg  <= beeps_left_next;
            sounding_reg    <= sounding_next;
            frequency_reg   <= frequency_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            tone_valid_reg <= 1'b1;
        end
        else if (!tone_stall)
        begin
            tone_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tone_word_reg.tone_on <= sounding_next;
            tone_word_reg.tone_hz <= frequency_next;
        end
    end

`ifndef NO_ASSERTIONS
    // melody index stays inside the melody while booting
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BOOT) |-> (note_index_reg < NOTE_W'(MELODY_NOTES)))
        else $error("note index past melody end in boot phase");

    // a sounding beep always has beeps left within its unit code
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TONE) |-> (sounding_reg && (beeps_left_reg != 3'd0)
            && (beeps_left_reg <= ({1'b0, unit_index_reg} + 3'd1))))
        else $error("tone phase with bad beep count or silent buzzer");

    // buzzer is silent in every gap phase
    assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_TONE_GAP) || (phase_reg == PH_UNIT_GAP)
            || (phase_reg == PH_REPEAT_GAP)) |-> !sounding_reg)
        else $error("buzzer sounding during a gap");

    // an evaluated event always lands in the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (tone_valid_reg && (tone_word_reg.tone_on == sounding_reg)
            && (tone_word_reg.tone_hz == frequency_reg)))
        else $error("result register does not match sequencer state");
`endif

endmodule
`default_nettype wire

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the beep-code alert sequencer core. A scoreboard
// class tracks the buzzer in its own model of the boot melody and the offline
// beep codes and checks every tone word against it. Events come in random
// bursts of boot/update sequences under several register settings, while
// the tone side stalls on changing patterns.
// ----------------------------------------------------------------------------
module testbench;
    import bcas_pkg::*;

    localparam int         MELODY_LEN = 3;
    localparam logic [2:0] REG_NONE   = 3'd7;   // outside the register file

    typedef enum int {SET_ZERO, SET_MAX, SET_SHORT, SET_WIDE, SET_MIXED} setting_t;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_EVERY3} stall_mode_t;

    // buzzer model and queue of tone words still owed by the block
    class buzzer_check;
        tone_word_t   tones_due[$];
        logic [15:0]  regs [7];
        phase_t       phase;
        logic [31:0]  deadline;
        logic [31:0]  enable_at;
        int unsigned  note_idx;
        logic [3:0]   active_mask;
        int unsigned  unit_idx;
        int unsigned  beeps_left;
        logic         sounding;
        logic [15:0]  freq;
        int           errors;
        int           checked;
        int           events;
        int           starts;
        int           beeps;

        function new();
            regs[REG_NOTE_MS]       = 16'd250;
            regs[REG_GRACE_MS]      = 16'd2000;
            regs[REG_ALARM_HZ]      = 16'd1000;
            regs[REG_BEEP_MS]       = 16'd120;
            regs[REG_BEEP_GAP_MS]   = 16'd120;
            regs[REG_UNIT_GAP_MS]   = 16'd500;
            regs[REG_REPEAT_GAP_MS] = 16'd2000;
            phase       = PH_BOOT;
            deadline    = '0;
            enable_at   = '0;
            note_idx    = 0;
            active_mask = '0;
            unit_idx    = 0;
            beeps_left  = 0;
            sounding    = 1'b0;
            freq        = '0;
            errors      = 0;
            checked     = 0;
            events      = 0;
            starts      = 0;
            beeps       = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [15:0] value);
            if (idx <= REG_REPEAT_GAP_MS)
                regs[idx] = value;
        endfunction

        // longest of the timing registers
        function int unsigned longest_wait();
            int unsigned m;
            m = 0;
            for (int i = 0; i < 7; i++)
                if (3'(i) != REG_ALARM_HZ && regs[i] > m)
                    m = regs[i];
            return m;
        endfunction

        // deadline reached when the wrapped difference is not negative
        function bit due(logic [31:0] now, logic [31:0] when);
            logic [31:0] diff;
            diff = now - when;
            return !diff[31];
        endfunction

        function logic [15:0] note_hz(int unsigned idx);
            case (idx & 7)
                0:       return MELODY_HZ_0;
                1:       return MELODY_HZ_1;
                default: return MELODY_HZ_LAST;
            endcase
        endfunction

        // lowest offline unit at or above from
        function bit next_unit(logic [3:0] mask, int unsigned from, output int unsigned hit);
            for (int unsigned i = from; i < UNIT_COUNT && i < 4; i++)
            begin
                if (mask[i])
                begin
                    hit = i;
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void sound(logic [15:0] hz);
            freq     = hz;
            sounding = 1'b1;
        endfunction

        function void begin_beep(logic [31:0] now);
            sound(regs[REG_ALARM_HZ]);
            phase    = PH_TONE;
            deadline = now + 32'(regs[REG_BEEP_MS]);
            beeps++;
        endfunction

        function void begin_report(logic [31:0] now, logic [3:0] mask);
            int unsigned u;
            if (next_unit(mask, 0, u))
            begin
                unit_idx   = u;
                beeps_left = u + 1;
                begin_beep(now);
            end
        endfunction

        // one update event
        function void advance(logic [31:0] now, logic [3:0] mask);
            int unsigned nxt;
            if (phase == PH_BOOT)
            begin
                if (!due(now, deadline))
                    return;
                note_idx++;
                if (note_idx < MELODY_LEN)
                begin
                    sound(note_hz(note_idx));
                    deadline = now + 32'(regs[REG_NOTE_MS]);
                end
                else
                begin
                    sounding  = 1'b0;
                    phase     = PH_IDLE;
                    enable_at = now + 32'(regs[REG_GRACE_MS]);
                end
                return;
            end
            if (!due(now, enable_at))
                return;
            // mask change silences and restarts the report
            if (mask != active_mask)
            begin
                active_mask = mask;
                phase       = PH_IDLE;
                sounding    = 1'b0;
            end
            if (mask == 4'h0)
                return;
            if (phase == PH_IDLE)
            begin
                begin_report(now, mask);
                return;
            end
            if (!due(now, deadline))
                return;
            case (phase) inside
                PH_TONE:
                begin
                    sounding = 1'b0;
                    if (beeps_left > 0)
                        beeps_left--;
                    if (beeps_left > 0)
                    begin
                        phase    = PH_TONE_GAP;
                        deadline = now + 32'(regs[REG_BEEP_GAP_MS]);
                    end
                    else if (next_unit(mask, unit_idx + 1, nxt))
                    begin
                        unit_idx   = nxt;
                        beeps_left = nxt + 1;
                        phase      = PH_UNIT_GAP;
                        deadline   = now + 32'(regs[REG_UNIT_GAP_MS]);
                    end
                    else
                    begin
                        phase    = PH_REPEAT_GAP;
                        deadline = now + 32'(regs[REG_REPEAT_GAP_MS]);
                    end
                end
                PH_TONE_GAP, PH_UNIT_GAP: begin_beep(now);
                PH_REPEAT_GAP:            begin_report(now, mask);
                default: ;
            endcase
        endfunction

        // accepted event word: work out the tone word it leads to
        function void take_event(evt_word_t e);
            tone_word_t w;
            if (e.action == ACT_START)
            begin
                phase       = PH_BOOT;
                deadline    = e.now_ms + 32'(regs[REG_NOTE_MS]);
                enable_at   = '0;
                note_idx    = 0;
                active_mask = '0;
                unit_idx    = 0;
                beeps_left  = 0;
                sound(MELODY_HZ_0);
                starts++;
            end
            else
                advance(e.now_ms, e.offline_mask);
            events++;
            w.tone_on = sounding;
            w.tone_hz = freq;
            tones_due.push_back(w);
        endfunction

        // printing stops after a while, counting does not
        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        task match_tone(tone_word_t got);
            tone_word_t want;
            if (tones_due.size() == 0)
            begin
                report($sformatf("tone word %0b/%0d with none owed", got.tone_on, got.tone_hz));
                return;
            end
            want = tones_due.pop_front();
            checked++;
            if (got.tone_on !== want.tone_on)
                report($sformatf("word %0d tone_on %0b, want %0b",
                                 checked, got.tone_on, want.tone_on));
            if (got.tone_hz !== want.tone_hz)
                report($sformatf("word %0d tone_hz %0d, want %0d",
                                 checked, got.tone_hz, want.tone_hz));
        endtask
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        evt_valid  = 1'b0;
    logic        evt_stall;
    evt_word_t   evt        = '0;
    logic        tone_valid;
    logic        tone_stall = 1'b0;
    tone_word_t  tone;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index  = '0;
    logic [15:0] cfg_data   = '0;

    buzzer_check sb;
    int          burst_left = 0;
    int          settings   = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          stall_tick = 0;

    beep_code_alert_sequencer_core #(
        .MELODY_NOTES(MELODY_LEN)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt),
        .tone_valid (tone_valid),
        .tone_stall (tone_stall),
        .tone       (tone),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    // run limit
    initial
    begin
        #8_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    // tone side: check accepted words, stall on a changing pattern
    always @(posedge clk)
    begin
        if (rst_n && tone_valid && !tone_stall)
            sb.match_tone(tone);
        if (mode_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            STALL_NONE:  tone_stall <= 1'b0;
            STALL_LIGHT: tone_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: tone_stall <= ($urandom_range(0, 3) != 0);
            default:     tone_stall <= (stall_tick % 3 == 0);
        endcase
        stall_tick <= stall_tick + 1;
    end

    function automatic evt_word_t mk(logic act, logic [31:0] now, logic [3:0] mask);
        evt_word_t e;
        e.action       = act;
        e.now_ms       = now;
        e.offline_mask = mask;
        return e;
    endfunction

    // hold one event word until it is taken
    task drive_event(evt_word_t e);
        evt_valid <= 1'b1;
        evt       <= e;
        do
            @(posedge clk);
        while (evt_stall !== 1'b0);
        sb.take_event(e);
    endtask

    // event side works in bursts with random gaps
    task push_event(evt_word_t e);
        if (burst_left == 0)
        begin
            evt_valid <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(7, 20)) @(posedge clk);
            else
                repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        drive_event(e);
        burst_left--;
    endtask

    task write_reg(logic [2:0] idx, logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        sb.set_reg(idx, value);
    endtask

    // stop sending and wait for every owed tone word
    task settle();
        evt_valid <= 1'b0;
        burst_left = 0;
        while (sb.tones_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_value(setting_t kind, logic [2:0] idx);
        bit tone_reg;
        tone_reg = (idx == REG_ALARM_HZ);
        case (kind)
            SET_ZERO:  return tone_reg ? 16'd1 : 16'd0;
            SET_MAX:   return 16'hFFFF;
            SET_SHORT: return tone_reg ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(0, 40));
            SET_WIDE:  return tone_reg ? 16'($urandom_range(1, 65535)) : 16'($urandom);
            default:
            begin
                case ($urandom_range(0, 2))
                    0:       return tone_reg ? 16'd1 : 16'd0;
                    1:       return 16'hFFFF;
                    default: return tone_reg ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(0, 40));
                endcase
            end
        endcase
    endfunction

    task apply_setting(setting_t kind);
        for (int i = 0; i < 7; i++)
            write_reg(3'(i), pick_value(kind, 3'(i)));
        if (kind == SET_SHORT || kind == SET_WIDE)
            write_reg(REG_NONE, 16'($urandom));
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings++;
    endtask

    // time advance, mostly short against the current waits
    function automatic logic [31:0] time_step();
        case ($urandom_range(0, 2))
            0:       return 32'($urandom_range(0, 4));
            1:       return 32'($urandom_range(0, 64));
            default: return 32'($urandom_range(0, sb.longest_wait() + 1));
        endcase
    endfunction

    task run_directed();
        // updates before any start walk the melody from time zero
        push_event(mk(ACT_UPDATE, 32'd0, 4'h0));
        push_event(mk(ACT_UPDATE, 32'd100, 4'hF));
        // boot melody and grace period
        push_event(mk(ACT_START, 32'd1000, 4'hF));
        push_event(mk(ACT_UPDATE, 32'd1249, 4'h0));
        push_event(mk(ACT_UPDATE, 32'd1250, 4'h0));
        push_event(mk(ACT_UPDATE, 32'd1500, 4'h0));
        push_event(mk(ACT_UPDATE, 32'd1750, 4'h0));
        push_event(mk(ACT_UPDATE, 32'd3749, 4'hF));
        // single unit code, then its repeat
        push_event(mk(ACT_UPDATE, 32'd3750, 4'h1));
        push_event(mk(ACT_UPDATE, 32'd3870, 4'h1));
        push_event(mk(ACT_UPDATE, 32'd5870, 4'h1));
        // mask change restarts the report, walk through unit gap and beep gap
        push_event(mk(ACT_UPDATE, 32'd5900, 4'hF));
        push_event(mk(ACT_UPDATE, 32'd6020, 4'hF));
        push_event(mk(ACT_UPDATE, 32'd6520, 4'hF));
        push_event(mk(ACT_UPDATE, 32'd6640, 4'hF));
        push_event(mk(ACT_UPDATE, 32'd6760, 4'hF));
        // mask cleared, then only the top unit
        push_event(mk(ACT_UPDATE, 32'd6770, 4'h0));
        push_event(mk(ACT_UPDATE, 32'd6780, 4'h8));
        // start just before the time wraps
        push_event(mk(ACT_START, 32'hFFFF_FFF0, 4'h0));
        push_event(mk(ACT_UPDATE, 32'h0000_0010, 4'h0));
        push_event(mk(ACT_UPDATE, 32'h0000_00EA, 4'h0));
        // more than half the time range away reads as not yet reached
        push_event(mk(ACT_UPDATE, 32'h8000_0200, 4'h5));
        push_event(mk(ACT_UPDATE, 32'hFFFF_FFFF, 4'hF));
    endtask

    // boot/update sequences with steady masks, plus noise and broken runs
    task run_random(int budget);
        int          sent;
        int          len;
        int          r;
        logic [31:0] t;
        logic [3:0]  m;
        sent = 0;
        t    = $urandom;
        while (sent < budget)
        begin
            len = $urandom_range(10, 80);
            if ($urandom_range(0, 3) == 0)
                t = 32'hFFFF_FFFF - 32'($urandom_range(0, 3000));
            m = ($urandom_range(0, 4) == 0) ? 4'h0 : 4'($urandom_range(1, 15));
            if ($urandom_range(0, 4) != 0)
            begin
                push_event(mk(ACT_START, t, 4'($urandom)));
                sent++;
            end
            for (int k = 0; k < len && sent < budget; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    push_event(mk(ACT_UPDATE, $urandom, 4'($urandom)));
                else if (r < 6)
                    push_event(mk(ACT_START, t, m));
                else
                begin
                    if (r < 10)
                        m = 4'($urandom);
                    t = t + time_step();
                    push_event(mk(ACT_UPDATE, t, m));
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        setting_t plan [8];
        plan = '{SET_SHORT, SET_ZERO, SET_WIDE, SET_MAX, SET_MIXED,
                 SET_SHORT, SET_WIDE, SET_MIXED};
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a write past the last register must change nothing
        write_reg(REG_NONE, 16'hFFFF);
        cfg_valid <= 1'b0;
        @(posedge clk);

        run_directed();
        settle();

        foreach (plan[p])
        begin
            apply_setting(plan[p]);
            run_random(240);
            settle();
        end

        repeat (8) @(posedge clk);
        $display("summary: %0d events (%0d starts) over %0d register settings",
                 sb.events, sb.starts, settings);
        $display("summary: %0d tone words checked, %0d alarm beeps, %0d mismatches",
                 sb.checked, sb.beeps, sb.errors);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
